/* sv/gdncu_pkg.sv */
`default_nettype none

package gdncu_pkg;

    // Field widths
    localparam int JDN_W   = 23;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int AMT_W   = 21;

    // Supported span: 0001-01-01 .. 9999-12-31
    localparam logic [JDN_W-1:0] JDN_MIN = 23'd1721426;
    localparam logic [JDN_W-1:0] JDN_MAX = 23'd5373484;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // Action codes
    localparam logic [1:0] ACT_TO_JDN     = 2'd0;
    localparam logic [1:0] ACT_TO_DATE    = 2'd1;
    localparam logic [1:0] ACT_ADD_DAYS   = 2'd2;
    localparam logic [1:0] ACT_ADD_MONTHS = 2'd3;

    // Calendar constants
    localparam int JDN_OFS   = 32044;
    localparam int JDN_EPOCH = 32045;
    localparam int YEAR_OFS  = 4800;

    // Month arithmetic runs on a positive biased count: total + 12 * YEAR_BIAS
    localparam int YEAR_BIAS  = 87382;
    localparam int MONTH_BIAS = 12 * YEAR_BIAS;

    // Stage counts of the converters and of the whole pipeline
    localparam int J2D_LAT  = 6;
    localparam int D2J_LAT  = 3;
    localparam int PIPE_LAT = 1 + J2D_LAT + 5 + D2J_LAT + 1 + J2D_LAT + 1;

    // Reciprocals: floor(x / D) == (x * ceil(2^K / D)) >> K for x < 2^N, K = N + clog2(D)
    localparam int K_146097 = 44;   // N = 26
    localparam logic [26:0] RCP_146097 =
        27'(((64'd1 << K_146097) + 64'd146096) / 64'd146097);
    localparam int K_1461 = 30;     // N = 19
    localparam logic [19:0] RCP_1461 =
        20'(((64'd1 << K_1461) + 64'd1460) / 64'd1461);
    localparam int K_153 = 20;      // N = 12
    localparam logic [12:0] RCP_153 =
        13'(((64'd1 << K_153) + 64'd152) / 64'd153);
    localparam int K_12 = 26;       // N = 22
    localparam logic [22:0] RCP_12 =
        23'(((64'd1 << K_12) + 64'd11) / 64'd12);
    localparam int K_100 = 22;      // N = 15
    localparam logic [15:0] RCP_100 =
        16'(((64'd1 << K_100) + 64'd99) / 64'd100);

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Days before March-based month mm: (153 * mm + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] ofs;
        case (mm)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            4'd1,
            4'd3,
            4'd5,
            4'd7,
            4'd8,
            4'd10,
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* sv/gregorian_day_number_calendar_unit.sv */
`default_nettype none

// Throughput: one word per cycle; busy stays low, results leave one per cycle in order.
// Most of the depth comes from three converter chains in series:
// day number to date (6), date back to day number (3), and day number to date again (6).
// Reset clears only the valid pipeline; the receiver cannot stall, so done is never held.
module gregorian_day_number_calendar_unit (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire [1:0]                              action,
    input  wire [gdncu_pkg::YEAR_W-1:0]            in_year,
    input  wire [gdncu_pkg::MONTH_W-1:0]           in_month,
    input  wire [gdncu_pkg::DAY_W-1:0]             in_day,
    input  wire [gdncu_pkg::JDN_W-1:0]             in_day_number,
    input  wire signed [gdncu_pkg::AMT_W-1:0]      amount,
    output logic                                   done,
    output logic [gdncu_pkg::JDN_W-1:0]            out_day_number,
    output logic [gdncu_pkg::YEAR_W-1:0]           out_year,
    output logic [gdncu_pkg::MONTH_W-1:0]          out_month,
    output logic [gdncu_pkg::DAY_W-1:0]            out_day,
    output logic                                   valid_res
);

    localparam int LAT = gdncu_pkg::PIPE_LAT;
    localparam int JL  = gdncu_pkg::J2D_LAT;
    localparam int DL  = gdncu_pkg::D2J_LAT;

    // Per-word side data that rides alongside the converters
    typedef struct packed {
        logic [1:0]                          action;
        gdncu_pkg::date_t                    date;
        logic [gdncu_pkg::JDN_W-1:0]         jdn;
        logic signed [gdncu_pkg::AMT_W-1:0]  amount;
        logic                                jdn_ok;
        logic [gdncu_pkg::JDN_W-1:0]         dsum;
        logic                                dsum_ok;
    } side_t;

    // ------------------------------------------------------------------
    // Valid pipeline: one bit per stage, the only state that reset clears
    // ------------------------------------------------------------------
    logic           accept;
    logic [LAT-1:0] vld_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 0: capture the word, range-check the day number and the day sum
    // ------------------------------------------------------------------
    logic signed [24:0] dsum_wide;
    side_t              s0_next;
    side_t              s0_reg;

    always_comb
    begin
        dsum_wide          = $signed({2'b00, in_day_number})
                           + $signed({{4{amount[gdncu_pkg::AMT_W-1]}}, amount});
        s0_next.action     = action;
        s0_next.date.year  = in_year;
        s0_next.date.month = in_month;
        s0_next.date.day   = in_day;
        s0_next.jdn        = in_day_number;
        s0_next.amount     = amount;
        s0_next.jdn_ok     = (in_day_number >= gdncu_pkg::JDN_MIN)
                          && (in_day_number <= gdncu_pkg::JDN_MAX);
        s0_next.dsum       = dsum_wide[22:0];
        s0_next.dsum_ok    = (dsum_wide >= $signed({2'b00, gdncu_pkg::JDN_MIN}))
                          && (dsum_wide <= $signed({2'b00, gdncu_pkg::JDN_MAX}));
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
    end

    // ------------------------------------------------------------------
    // Decode the operand day number (needed by add-months)
    // ------------------------------------------------------------------
    gdncu_pkg::date_t j1_date;
    side_t            j1_dly_reg [JL];

    gdncu_jdn2date u_j1 (
        .clk  (clk),
        .jdn  (s0_reg.jdn),
        .date (j1_date)
    );

    always_ff @(posedge clk)
    begin
        j1_dly_reg[0] <= s0_reg;
        for (int i = 1; i < JL; i++)
        begin
            j1_dly_reg[i] <= j1_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage MA: biased month count 12*y + (m-1) + amount + 12*YEAR_BIAS
    // ------------------------------------------------------------------
    side_t              ma_side;
    logic [17:0]        y12;
    logic signed [24:0] total_wide;
    side_t              ma_side_reg;
    logic [4:0]         ma_day_reg;
    logic [21:0]        ma_total_reg;

    assign ma_side    = j1_dly_reg[JL-1];
    assign y12        = ({4'd0, j1_date.year} << 3) + ({4'd0, j1_date.year} << 2);
    assign total_wide = $signed({7'd0, y12}) + $signed({21'd0, j1_date.month})
                      + $signed(25'(gdncu_pkg::MONTH_BIAS - 1))
                      + $signed({{4{ma_side.amount[gdncu_pkg::AMT_W-1]}}, ma_side.amount});

    always_ff @(posedge clk)
    begin
        ma_side_reg  <= ma_side;
        ma_day_reg   <= j1_date.day;
        ma_total_reg <= total_wide[21:0];
    end

    // ------------------------------------------------------------------
    // Stage MB: divide the month count by 12
    // ------------------------------------------------------------------
    logic [44:0] p12;
    side_t       mb_side_reg;
    logic [4:0]  mb_day_reg;
    logic [21:0] mb_total_reg;
    logic [18:0] mb_q_reg;

    assign p12 = 45'(ma_total_reg) * 45'(gdncu_pkg::RCP_12);

    always_ff @(posedge clk)
    begin
        mb_side_reg  <= ma_side_reg;
        mb_day_reg   <= ma_day_reg;
        mb_total_reg <= ma_total_reg;
        mb_q_reg     <= p12[gdncu_pkg::K_12+18:gdncu_pkg::K_12];
    end

    // ------------------------------------------------------------------
    // Stage MC: pick the date that goes on to the day-number encoder and
    // gather the range checks known so far
    // ------------------------------------------------------------------
    logic [21:0] q12x;
    logic [21:0] rem_wide;
    logic [18:0] ny_wide;
    logic        ny_ok;
    side_t       mc_next;
    logic        mc_ok_next;
    side_t       mc_side_reg;
    logic        mc_ok_reg;

    always_comb
    begin
        q12x     = 22'(mb_q_reg) * 22'd12;
        rem_wide = mb_total_reg - q12x;
        ny_wide  = mb_q_reg - 19'(gdncu_pkg::YEAR_BIAS);
        ny_ok    = (mb_q_reg >= 19'(gdncu_pkg::YEAR_BIAS + 1))
                && (mb_q_reg <= 19'(gdncu_pkg::YEAR_BIAS + 9999));
        mc_next  = mb_side_reg;
        case (mb_side_reg.action)
            gdncu_pkg::ACT_TO_JDN:
            begin
                mc_ok_next = (mb_side_reg.date.year >= 14'd1)
                          && (mb_side_reg.date.year <= gdncu_pkg::YEAR_MAX)
                          && (mb_side_reg.date.month >= 4'd1)
                          && (mb_side_reg.date.month <= 4'd12)
                          && (mb_side_reg.date.day >= 5'd1);
            end
            gdncu_pkg::ACT_TO_DATE:
            begin
                mc_ok_next = mb_side_reg.jdn_ok;
            end
            gdncu_pkg::ACT_ADD_DAYS:
            begin
                mc_ok_next = mb_side_reg.jdn_ok && mb_side_reg.dsum_ok;
            end
            gdncu_pkg::ACT_ADD_MONTHS:
            begin
                mc_ok_next          = mb_side_reg.jdn_ok && ny_ok;
                mc_next.date.year   = ny_wide[13:0];
                mc_next.date.month  = rem_wide[3:0] + 4'd1;
                mc_next.date.day    = mb_day_reg;
            end
            default:
            begin
                mc_ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mc_side_reg <= mc_next;
        mc_ok_reg   <= mc_ok_next;
    end

    // ------------------------------------------------------------------
    // Stage LA: century count of the selected year, for the leap test
    // ------------------------------------------------------------------
    logic [30:0] p100;
    side_t       la_side_reg;
    logic        la_ok_reg;
    logic [7:0]  la_q_reg;

    assign p100 = 31'({1'b0, mc_side_reg.date.year}) * 31'(gdncu_pkg::RCP_100);

    always_ff @(posedge clk)
    begin
        la_side_reg <= mc_side_reg;
        la_ok_reg   <= mc_ok_reg;
        la_q_reg    <= p100[gdncu_pkg::K_100+7:gdncu_pkg::K_100];
    end

    // ------------------------------------------------------------------
    // Stage LB: month length with leap years; check the day for a date
    // input, clamp it for a month sum
    // ------------------------------------------------------------------
    logic [13:0] hund;
    logic [13:0] rem100;
    logic        leap;
    logic [4:0]  dim;
    side_t       lb_next;
    logic        lb_ok_next;
    side_t       lb_side_reg;
    logic        lb_ok_reg;

    always_comb
    begin
        hund       = 14'(la_q_reg) * 14'd100;
        rem100     = la_side_reg.date.year - hund;
        leap       = ((la_side_reg.date.year[1:0] == 2'b00) && (rem100 != 14'd0))
                  || ((rem100 == 14'd0) && (la_q_reg[1:0] == 2'b00));
        dim        = gdncu_pkg::month_days(la_side_reg.date.month, leap);
        lb_next    = la_side_reg;
        lb_ok_next = la_ok_reg;
        case (la_side_reg.action)
            gdncu_pkg::ACT_TO_JDN:
            begin
                lb_ok_next = la_ok_reg && (la_side_reg.date.day <= dim);
            end
            gdncu_pkg::ACT_ADD_MONTHS:
            begin
                if (la_side_reg.date.day > dim)
                begin
                    lb_next.date.day = dim;
                end
            end
            default:
            begin
                lb_ok_next = la_ok_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lb_side_reg <= lb_next;
        lb_ok_reg   <= lb_ok_next;
    end

    // ------------------------------------------------------------------
    // Encode the date into a day number
    // ------------------------------------------------------------------
    logic [gdncu_pkg::JDN_W-1:0] d2j_jdn;
    side_t                       d2j_side_reg [DL];
    logic                        d2j_ok_reg   [DL];

    gdncu_date2jdn u_d2j (
        .clk  (clk),
        .date (lb_side_reg.date),
        .jdn  (d2j_jdn)
    );

    always_ff @(posedge clk)
    begin
        d2j_side_reg[0] <= lb_side_reg;
        d2j_ok_reg[0]   <= lb_ok_reg;
        for (int i = 1; i < DL; i++)
        begin
            d2j_side_reg[i] <= d2j_side_reg[i-1];
            d2j_ok_reg[i]   <= d2j_ok_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage RS: select the result day number
    // ------------------------------------------------------------------
    side_t                       rs_side;
    logic [gdncu_pkg::JDN_W-1:0] rs_jdn_next;
    logic [gdncu_pkg::JDN_W-1:0] rs_jdn_reg;
    logic                        rs_ok_reg;

    assign rs_side = d2j_side_reg[DL-1];

    always_comb
    begin
        case (rs_side.action)
            gdncu_pkg::ACT_TO_JDN:     rs_jdn_next = d2j_jdn;
            gdncu_pkg::ACT_TO_DATE:    rs_jdn_next = rs_side.jdn;
            gdncu_pkg::ACT_ADD_DAYS:   rs_jdn_next = rs_side.dsum;
            gdncu_pkg::ACT_ADD_MONTHS: rs_jdn_next = d2j_jdn;
            default:                   rs_jdn_next = rs_side.jdn;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rs_jdn_reg <= rs_jdn_next;
        rs_ok_reg  <= d2j_ok_reg[DL-1];
    end

    // ------------------------------------------------------------------
    // Decode the result day number into the result date
    // ------------------------------------------------------------------
    gdncu_pkg::date_t            j2_date;
    logic [gdncu_pkg::JDN_W-1:0] j2_jdn_reg [JL];
    logic                        j2_ok_reg  [JL];

    gdncu_jdn2date u_j2 (
        .clk  (clk),
        .jdn  (rs_jdn_reg),
        .date (j2_date)
    );

    always_ff @(posedge clk)
    begin
        j2_jdn_reg[0] <= rs_jdn_reg;
        j2_ok_reg[0]  <= rs_ok_reg;
        for (int i = 1; i < JL; i++)
        begin
            j2_jdn_reg[i] <= j2_jdn_reg[i-1];
            j2_ok_reg[i]  <= j2_ok_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register: drop the fields to zero on a range failure
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (j2_ok_reg[JL-1])
        begin
            out_day_number <= j2_jdn_reg[JL-1];
            out_year       <= j2_date.year;
            out_month      <= j2_date.month;
            out_day        <= j2_date.day;
            valid_res      <= 1'b1;
        end
        else
        begin
            out_day_number <= '0;
            out_year       <= '0;
            out_month      <= '0;
            out_day        <= '0;
            valid_res      <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word produced no result after pipeline latency");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted word");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> ((out_month >= 4'd1) && (out_month <= 4'd12)
                              && (out_day >= 5'd1) && (out_day <= 5'd31)
                              && (out_year >= 14'd1) && (out_year <= gdncu_pkg::YEAR_MAX)))
        else $error("valid result carries an impossible date");

    a_round_trip: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == gdncu_pkg::ACT_TO_DATE)
         && (in_day_number >= gdncu_pkg::JDN_MIN)
         && (in_day_number <= gdncu_pkg::JDN_MAX))
        |-> ##LAT (done && valid_res && (out_day_number == $past(in_day_number, LAT))))
        else $error("day number to date lost its day number");

endmodule

`default_nettype wire

/* sv/gdncu_jdn2date.sv */
`default_nettype none

module gdncu_jdn2date (
    input  wire                            clk,
    input  wire [gdncu_pkg::JDN_W-1:0]     jdn,
    output gdncu_pkg::date_t               date
);

    // Stage 1: a = jdn + 32044, b = (4a + 3) / 146097
    logic [23:0] a_next;
    logic [25:0] x1;
    logic [52:0] p1;
    logic [23:0] a1_reg;
    logic [8:0]  b1_reg;

    assign a_next = 24'(jdn) + 24'(gdncu_pkg::JDN_OFS);
    assign x1     = {a_next, 2'b11};
    assign p1     = 53'(x1) * 53'(gdncu_pkg::RCP_146097);

    always_ff @(posedge clk)
    begin
        a1_reg <= a_next;
        b1_reg <= p1[gdncu_pkg::K_146097+8:gdncu_pkg::K_146097];
    end

    // Stage 2: c = a - 146097 * b / 4
    logic [26:0] p2;
    logic [24:0] c_wide;
    logic [16:0] c2_reg;
    logic [8:0]  b2_reg;

    assign p2     = 27'(b1_reg) * 27'd146097;
    assign c_wide = {1'b0, a1_reg} - p2[26:2];

    always_ff @(posedge clk)
    begin
        c2_reg <= c_wide[16:0];
        b2_reg <= b1_reg;
    end

    // Stage 3: e4 = (4c + 3) / 1461
    logic [18:0] x3;
    logic [38:0] p3;
    logic [16:0] c3_reg;
    logic [6:0]  e4_3_reg;
    logic [8:0]  b3_reg;

    assign x3 = {c2_reg, 2'b11};
    assign p3 = 39'(x3) * 39'(gdncu_pkg::RCP_1461);

    always_ff @(posedge clk)
    begin
        c3_reg   <= c2_reg;
        e4_3_reg <= p3[gdncu_pkg::K_1461+6:gdncu_pkg::K_1461];
        b3_reg   <= b2_reg;
    end

    // Stage 4: e = c - 1461 * e4 / 4
    logic [17:0] p4;
    logic [16:0] e_wide;
    logic [8:0]  e4_reg;
    logic [6:0]  e4_4_reg;
    logic [8:0]  b4_reg;

    assign p4     = 18'(e4_3_reg) * 18'd1461;
    assign e_wide = c3_reg - 17'(p4[17:2]);

    always_ff @(posedge clk)
    begin
        e4_reg   <= e_wide[8:0];
        e4_4_reg <= e4_3_reg;
        b4_reg   <= b3_reg;
    end

    // Stage 5: mm = (5e + 2) / 153, partial year 100b + e4
    logic [11:0] x5;
    logic [24:0] p5;
    logic [3:0]  mm5_reg;
    logic [8:0]  e5_reg;
    logic [15:0] yb5_reg;

    assign x5 = 12'({e4_reg, 2'b00}) + 12'(e4_reg) + 12'd2;
    assign p5 = 25'(x5) * 25'(gdncu_pkg::RCP_153);

    always_ff @(posedge clk)
    begin
        mm5_reg <= p5[gdncu_pkg::K_153+3:gdncu_pkg::K_153];
        e5_reg  <= e4_reg;
        yb5_reg <= 16'(b4_reg) * 16'd100 + 16'(e4_4_reg);
    end

    // Stage 6: day of month; fold the March-based month and year back to January-based
    logic             wrap;
    logic [8:0]       day_wide;
    logic [15:0]      year_wide;
    gdncu_pkg::date_t date_next;
    gdncu_pkg::date_t date_reg;

    always_comb
    begin
        wrap            = (mm5_reg >= 4'd10);
        day_wide        = e5_reg - gdncu_pkg::month_offset(mm5_reg) + 9'd1;
        year_wide       = yb5_reg - 16'(gdncu_pkg::YEAR_OFS) + 16'(wrap);
        date_next.day   = day_wide[4:0];
        date_next.month = wrap ? (mm5_reg - 4'd9) : (mm5_reg + 4'd3);
        date_next.year  = year_wide[13:0];
    end

    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
    end

    assign date = date_reg;

endmodule

`default_nettype wire

/* sv/gdncu_date2jdn.sv */
`default_nettype none

module gdncu_date2jdn (
    input  wire                            clk,
    input  wire gdncu_pkg::date_t          date,
    output logic [gdncu_pkg::JDN_W-1:0]    jdn
);

    // Stage 1: shift to a March-based year
    logic        early;
    logic [14:0] yy1_reg;
    logic [3:0]  mm1_reg;
    logic [4:0]  d1_reg;

    assign early = (date.month <= 4'd2);

    always_ff @(posedge clk)
    begin
        yy1_reg <= 15'(date.year) + 15'(gdncu_pkg::YEAR_OFS) - 15'(early);
        mm1_reg <= early ? (date.month + 4'd9) : (date.month - 4'd3);
        d1_reg  <= date.day;
    end

    // Stage 2: century count, year days, month offset
    logic [30:0] p100;
    logic [7:0]  q2_reg;
    logic [22:0] p365_2_reg;
    logic [12:0] quad2_reg;
    logic [8:0]  moff2_reg;
    logic [4:0]  d2_reg;

    assign p100 = 31'(yy1_reg) * 31'(gdncu_pkg::RCP_100);

    always_ff @(posedge clk)
    begin
        q2_reg     <= p100[gdncu_pkg::K_100+7:gdncu_pkg::K_100];
        p365_2_reg <= 23'(yy1_reg) * 23'd365;
        quad2_reg  <= yy1_reg[14:2];
        moff2_reg  <= gdncu_pkg::month_offset(mm1_reg);
        d2_reg     <= d1_reg;
    end

    // Stage 3: sum the terms
    logic [23:0] sum;
    logic [22:0] jdn_reg;

    assign sum = 24'(d2_reg) + 24'(moff2_reg) + 24'(p365_2_reg) + 24'(quad2_reg)
               - 24'(q2_reg) + 24'(q2_reg[7:2]) - 24'(gdncu_pkg::JDN_EPOCH);

    always_ff @(posedge clk)
    begin
        jdn_reg <= sum[22:0];
    end

    assign jdn = jdn_reg;

endmodule

`default_nettype wire

/* tb/tb_gregorian_day_number_calendar_unit.sv */
`timescale 1ns / 100ps

typedef logic [gdncu_pkg::JDN_W-1:0]          jdn_t;
typedef logic [gdncu_pkg::YEAR_W-1:0]         year_t;
typedef logic [gdncu_pkg::MONTH_W-1:0]        month_t;
typedef logic [gdncu_pkg::DAY_W-1:0]          day_t;
typedef logic signed [gdncu_pkg::AMT_W-1:0]   amount_t;

typedef struct packed {
    jdn_t   day_number;
    year_t  year;
    month_t month;
    day_t   day;
    logic   ok;
} calendar_answer_t;

typedef struct {
    logic [1:0]       action;
    calendar_answer_t answer;
} calendar_promise_t;

class calendar_book;
    calendar_promise_t promised[$];
    int unsigned       failures = 0;

    function bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function longint month_length(longint m, longint y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function bit in_span(longint j);
        return j >= longint'(gdncu_pkg::JDN_MIN) && j <= longint'(gdncu_pkg::JDN_MAX);
    endfunction

    function longint civil_to_day_number(longint y, longint m, longint d);
        longint a, yy, mm;
        a  = (14 - m) / 12;
        yy = y + 4800 - a;
        mm = m + 12 * a - 3;
        return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
    endfunction

    function void day_number_to_civil(longint j, output longint y, output longint m,
                                      output longint d);
        longint a, b, c, e4, e, mm;
        a  = j + 32044;
        b  = (4 * a + 3) / 146097;
        c  = a - (146097 * b) / 4;
        e4 = (4 * c + 3) / 1461;
        e  = c - (1461 * e4) / 4;
        mm = (5 * e + 2) / 153;
        d  = e - (153 * mm + 2) / 5 + 1;
        m  = mm + 3 - 12 * (mm / 10);
        y  = 100 * b + e4 - 4800 + mm / 10;
    endfunction

    function calendar_answer_t expected_answer(logic [1:0] act, year_t yr, month_t mo,
                                               day_t dy, jdn_t jdn, amount_t amt);
        longint iy, im, id, ij, da, total, ny, nm, nd, ry, rm, rd, rj;
        bit ok;
        calendar_answer_t ans;
        iy = yr;
        im = mo;
        id = dy;
        ij = jdn;
        da = amt;
        ok = 1'b0;
        rj = 0;
        case (act)
            gdncu_pkg::ACT_TO_JDN:
            begin
                if (iy >= 1 && iy <= 9999 && im >= 1 && im <= 12 &&
                    id >= 1 && id <= month_length(im, iy))
                begin
                    rj = civil_to_day_number(iy, im, id);
                    ok = 1'b1;
                end
            end
            gdncu_pkg::ACT_TO_DATE:
            begin
                if (in_span(ij))
                begin
                    rj = ij;
                    ok = 1'b1;
                end
            end
            gdncu_pkg::ACT_ADD_DAYS:
            begin
                if (in_span(ij) && in_span(ij + da))
                begin
                    rj = ij + da;
                    ok = 1'b1;
                end
            end
            default:
            begin
                if (in_span(ij))
                begin
                    day_number_to_civil(ij, ry, rm, rd);
                    total = ry * 12 + (rm - 1) + da;
                    ny = total / 12;
                    nm = total % 12;
                    if (nm < 0)
                    begin
                        nm += 12;
                        ny -= 1;
                    end
                    nm += 1;
                    if (ny >= 1 && ny <= 9999)
                    begin
                        nd = (rd > month_length(nm, ny)) ? month_length(nm, ny) : rd;
                        rj = civil_to_day_number(ny, nm, nd);
                        ok = 1'b1;
                    end
                end
            end
        endcase
        ans = '0;
        if (ok)
        begin
            day_number_to_civil(rj, ry, rm, rd);
            ans.day_number = rj[gdncu_pkg::JDN_W-1:0];
            ans.year       = ry[gdncu_pkg::YEAR_W-1:0];
            ans.month      = rm[gdncu_pkg::MONTH_W-1:0];
            ans.day        = rd[gdncu_pkg::DAY_W-1:0];
            ans.ok         = 1'b1;
        end
        return ans;
    endfunction

    function void note_request(logic [1:0] act, year_t yr, month_t mo, day_t dy,
                               jdn_t jdn, amount_t amt);
        calendar_promise_t p;
        p.action = act;
        p.answer = expected_answer(act, yr, mo, dy, jdn, amt);
        promised.push_back(p);
    endfunction

    function void flag(string what, calendar_answer_t want, calendar_answer_t got);
        if (failures < 10)
            $display("%s: expected %0d %0d-%0d-%0d valid %0b, got %0d %0d-%0d-%0d valid %0b",
                     what, want.day_number, want.year, want.month, want.day, want.ok,
                     got.day_number, got.year, got.month, got.day, got.ok);
        failures++;
    endfunction

    function void check_answer(calendar_answer_t got);
        calendar_promise_t p;
        if (promised.size() == 0)
        begin
            flag("result with nothing pending", '0, got);
            return;
        end
        p = promised.pop_front();
        if (got.day_number !== p.answer.day_number || got.year !== p.answer.year ||
            got.month !== p.answer.month || got.day !== p.answer.day ||
            got.ok !== p.answer.ok)
            flag($sformatf("action %0d mismatch", p.action), p.answer, got);
    endfunction

    function int pending();
        return promised.size();
    endfunction
endclass

module tb_gregorian_day_number_calendar_unit;

    localparam int HALF_PERIOD = 10;

    // Hold every input at a known value from time zero.
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      start         = 1'b0;
    logic [1:0]                action        = gdncu_pkg::ACT_TO_JDN;
    year_t                     in_year       = '0;
    month_t                    in_month      = '0;
    day_t                      in_day        = '0;
    jdn_t                      in_day_number = '0;
    amount_t                   amount        = '0;

    logic                      busy;
    logic                      done;
    jdn_t                      out_day_number;
    year_t                     out_year;
    month_t                    out_month;
    day_t                      out_day;
    logic                      valid_res;

    // Percent chance, per cycle, that the sender holds start low before a word.
    int unsigned               gap_pct = 0;

    calendar_book              book = new();

    gregorian_day_number_calendar_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .in_year        (in_year),
        .in_month       (in_month),
        .in_day         (in_day),
        .in_day_number  (in_day_number),
        .amount         (amount),
        .done           (done),
        .out_day_number (out_day_number),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .valid_res      (valid_res)
    );

    always #HALF_PERIOD clk = ~clk;

    // Sample both sides at the rising edge, before the block's own updates land:
    // note each word taken on start && !busy, and check each strobed result
    // against the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            book.note_request(action, in_year, in_month, in_day, in_day_number, amount);
        if (rst_n && done)
            book.check_answer(calendar_answer_t'({out_day_number, out_year, out_month,
                                                  out_day, valid_res}));
    end

    // Enter at a falling edge; insert random idle cycles, present one word, hold it
    // until the block takes it, and return at the next falling edge.
    task automatic issue_word(input logic [1:0] act, input year_t yr, input month_t mo,
                              input day_t dy, input jdn_t jdn, input amount_t amt);
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start         = 1'b1;
        action        = act;
        in_year       = yr;
        in_month      = mo;
        in_day        = dy;
        in_day_number = jdn;
        amount        = amt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop start and hold off until every pending result has come back.
    task automatic wait_for_answers();
        start = 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    // Pick a day number inside the supported span: late in a random month (to
    // exercise clamping), close to either end of the span, or anywhere.
    function automatic jdn_t random_span_day();
        longint y, m, d;
        case ($urandom_range(3))
            0:
            begin
                y = $urandom_range(9999, 1);
                m = $urandom_range(12, 1);
                d = book.month_length(m, y) - $urandom_range(3);
                return jdn_t'(book.civil_to_day_number(y, m, d));
            end
            1:
                return $urandom_range(1) ? jdn_t'(gdncu_pkg::JDN_MIN + $urandom_range(400))
                                         : jdn_t'(gdncu_pkg::JDN_MAX - $urandom_range(400));
            default:
                return jdn_t'($urandom_range(gdncu_pkg::JDN_MAX, gdncu_pkg::JDN_MIN));
        endcase
    endfunction

    // Corners first: span ends, leap rules, impossible dates, clamping, and sums
    // that land just inside or just outside the span.
    task automatic directed_words();
        jdn_t jan31_2000, jan31_1900, mar31_2001, jun15_5000;
        jan31_2000 = jdn_t'(book.civil_to_day_number(2000, 1, 31));
        jan31_1900 = jdn_t'(book.civil_to_day_number(1900, 1, 31));
        mar31_2001 = jdn_t'(book.civil_to_day_number(2001, 3, 31));
        jun15_5000 = jdn_t'(book.civil_to_day_number(5000, 6, 15));

        issue_word(gdncu_pkg::ACT_TO_JDN, 1, 1, 1, '0, '0);
        issue_word(gdncu_pkg::ACT_TO_JDN, 9999, 12, 31, '0, '0);
        issue_word(gdncu_pkg::ACT_TO_JDN, 2000, 2, 29, '0, '0);
        // century, not leap
        issue_word(gdncu_pkg::ACT_TO_JDN, 1900, 2, 29, '0, '0);
        issue_word(gdncu_pkg::ACT_TO_JDN, 0, 6, 15, '0, '0);
        // all ones, impossible
        issue_word(gdncu_pkg::ACT_TO_JDN, '1, '1, '1, '1, '1);
        issue_word(gdncu_pkg::ACT_TO_JDN, 2023, 0, 0, '0, '0);
        issue_word(gdncu_pkg::ACT_TO_JDN, 2023, 4, 31, '0, '0);

        issue_word(gdncu_pkg::ACT_TO_DATE, '0, '0, '0, gdncu_pkg::JDN_MIN, '0);
        issue_word(gdncu_pkg::ACT_TO_DATE, '0, '0, '0, gdncu_pkg::JDN_MAX, '0);
        issue_word(gdncu_pkg::ACT_TO_DATE, '0, '0, '0, gdncu_pkg::JDN_MIN - 1'b1, '0);
        issue_word(gdncu_pkg::ACT_TO_DATE, '0, '0, '0, gdncu_pkg::JDN_MAX + 1'b1, '0);
        issue_word(gdncu_pkg::ACT_TO_DATE, '0, '0, '0, '1, '0);

        issue_word(gdncu_pkg::ACT_ADD_DAYS, '0, '0, '0, gdncu_pkg::JDN_MIN, amount_t'(1048575));
        issue_word(gdncu_pkg::ACT_ADD_DAYS, '0, '0, '0, gdncu_pkg::JDN_MAX, amount_t'(-1048576));
        issue_word(gdncu_pkg::ACT_ADD_DAYS, '0, '0, '0, gdncu_pkg::JDN_MAX, amount_t'(1));
        issue_word(gdncu_pkg::ACT_ADD_DAYS, '0, '0, '0, gdncu_pkg::JDN_MIN, amount_t'(-1));
        issue_word(gdncu_pkg::ACT_ADD_DAYS, '0, '0, '0, '0, amount_t'(5));

        // clamp to 29
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, jan31_2000, amount_t'(1));
        // clamp to 28
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, jan31_1900, amount_t'(1));
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, mar31_2001, amount_t'(-1));
        // year zero
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, gdncu_pkg::JDN_MIN, amount_t'(-1));
        // year 10000
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, gdncu_pkg::JDN_MAX, amount_t'(1));
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, jun15_5000, amount_t'(1048575));
        // back to year 1
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, gdncu_pkg::JDN_MAX,
                   amount_t'(-119987));
        issue_word(gdncu_pkg::ACT_ADD_MONTHS, '0, '0, '0, gdncu_pkg::JDN_MAX + 1'b1,
                   amount_t'(0));
    endtask

    // Mostly well-formed operands with random content; the rest is raw noise.
    // Unused fields always carry random bits.
    task automatic random_word();
        logic [1:0]  act;
        year_t       yr;
        month_t      mo;
        day_t        dy;
        jdn_t        jdn;
        amount_t     amt;
        int unsigned pick;
        act  = 2'($urandom_range(3));
        yr   = year_t'($urandom);
        mo   = month_t'($urandom);
        dy   = day_t'($urandom);
        jdn  = jdn_t'($urandom);
        amt  = amount_t'($urandom);
        pick = $urandom_range(99);
        case (act)
            gdncu_pkg::ACT_TO_JDN:
            begin
                if (pick < 85)
                begin
                    if (pick < 10)
                        yr = $urandom_range(1) ? year_t'(1 + $urandom_range(3))
                                               : year_t'(9999 - $urandom_range(3));
                    else
                        yr = year_t'($urandom_range(9999, 1));
                    mo = month_t'($urandom_range(12, 1));
                    dy = day_t'($urandom_range(31, 1));
                end
            end
            gdncu_pkg::ACT_TO_DATE:
            begin
                if (pick < 90)
                    jdn = random_span_day();
            end
            gdncu_pkg::ACT_ADD_DAYS:
            begin
                if (pick < 90)
                    jdn = random_span_day();
                if ($urandom_range(99) < 40)
                    amt = amount_t'(int'($urandom_range(2000)) - 1000);
            end
            default:
            begin
                if (pick < 90)
                    jdn = random_span_day();
                pick = $urandom_range(99);
                if (pick < 70)
                    amt = amount_t'(int'($urandom_range(480)) - 240);
                else if (pick < 80)
                    amt = amount_t'(int'($urandom_range(240000)) - 120000);
            end
        endcase
        issue_word(act, yr, mo, dy, jdn, amt);
    endtask

    // Stimulus: reset, corners, then three random phases with different sender
    // idling; settle with one extra drain mid-phase and between phases.
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_pct = 18;
        directed_words();
        for (int n = 0; n < 520; n++)
        begin
            random_word();
            if (n == 260)
                wait_for_answers();
        end
        wait_for_answers();

        gap_pct = 66;
        for (int n = 0; n < 520; n++)
            random_word();
        wait_for_answers();

        gap_pct = 0;
        for (int n = 0; n < 510; n++)
            random_word();
        wait_for_answers();

        // Leave time for any stray strobe past the pipeline depth.
        repeat (gdncu_pkg::PIPE_LAT + 8) @(negedge clk);
        if (book.failures == 0 && book.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a correct run takes well under a millisecond.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
sv/gdncu_pkg.sv
sv/gdncu_jdn2date.sv
sv/gdncu_date2jdn.sv
sv/gregorian_day_number_calendar_unit.sv
tb/tb_gregorian_day_number_calendar_unit.sv
